// ===== rtl/hufd_pkg.sv =====
// Shared types, constants and codes for the Huffman tree decoder.
package hufd_pkg;

	// Default sizes of the node store and the longest code
	localparam int DEF_MAX_NODES    = 512;
	localparam int DEF_MAX_CODE_LEN = 16;

	// Fixed field widths
	localparam int SYM_W  = 8;
	localparam int CODE_W = 16;
	localparam int LEN_W  = 5;

	// Item kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DECODE = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// Input transaction payload
	typedef struct packed {
		logic              kind;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
		logic              bit_req;
	} item_t;

	// Output transaction payload
	typedef struct packed {
		logic             symbol_valid;
		logic [SYM_W-1:0] out_symbol;
		logic [1:0]       status;
	} result_t;

	// Which result the datapath captures
	typedef enum logic [1:0] {
		RES_OK,
		RES_MISSING,
		RES_FULL,
		RES_SYMBOL
	} res_sel_t;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC_RD,
		S_DEC_EV,
		S_LEAF_RD,
		S_LEAF_EV,
		S_INS_RD,
		S_INS_EV,
		S_INS_INIT,
		S_FIN
	} ctl_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic     ld_item;
		logic     rd;
		logic     adv_link;
		logic     wr_link;
		logic     wr_init;
		logic     wr_tag;
		logic     set_res;
		res_sel_t res;
		logic     cur_zero;
		logic     cur_node;
		logic     ld_out;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic is_dec;
		logic len_zero;
		logic link_none;
		logic both_none;
		logic store_full;
	} sts_t;

endpackage

// ===== rtl/hufd_node_mem.sv =====
// Single-port-write, single-port-read node store with registered read data.
module hufd_node_mem import hufd_pkg::*; #(
	parameter int DEPTH = DEF_MAX_NODES,
	parameter int WIDTH = 2 * $clog2(DEF_MAX_NODES) + SYM_W
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [WIDTH-1:0]           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read one entry, data valid the next cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/hufd_ctrl.sv =====
// Controller state machine that sequences inserts, decodes and result hand-off.
module hufd_ctrl import hufd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  logic item_kind,
	input  logic result_stall,
	input  sts_t sts,
	output logic item_stall,
	output logic result_valid,
	output cmd_t cmd
);

	ctl_state_t state_q, state_d;
	logic       out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.ld_item = 1'b1;
					state_d     = (item_kind == KIND_DECODE) ? S_DEC_RD : S_INS_RD;
				end
			end
			S_DEC_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_DEC_EV;
			end
			S_DEC_EV: begin
				if (sts.link_none) begin
					cmd.set_res  = 1'b1;
					cmd.res      = RES_MISSING;
					cmd.cur_zero = 1'b1;
					state_d      = S_FIN;
				end else begin
					cmd.adv_link = 1'b1;
					state_d      = S_LEAF_RD;
				end
			end
			S_LEAF_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_LEAF_EV;
			end
			S_LEAF_EV: begin
				cmd.set_res = 1'b1;
				if (sts.both_none) begin
					cmd.res      = RES_SYMBOL;
					cmd.cur_zero = 1'b1;
				end else begin
					cmd.res      = RES_OK;
					cmd.cur_node = 1'b1;
				end
				state_d = S_FIN;
			end
			S_INS_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_INS_EV;
			end
			S_INS_EV: begin
				if (sts.len_zero) begin
					cmd.wr_tag  = 1'b1;
					cmd.set_res = 1'b1;
					cmd.res     = RES_OK;
					state_d     = S_FIN;
				end else if (!sts.link_none) begin
					cmd.adv_link = 1'b1;
					state_d      = S_INS_RD;
				end else if (sts.store_full) begin
					cmd.set_res = 1'b1;
					cmd.res     = RES_FULL;
					state_d     = S_FIN;
				end else begin
					cmd.wr_link = 1'b1;
					state_d     = S_INS_INIT;
				end
			end
			S_INS_INIT: begin
				cmd.wr_init = 1'b1;
				state_d     = S_INS_RD;
			end
			S_FIN: begin
				if (!out_valid_q || !result_stall) begin
					cmd.ld_out = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output valid: set on load, drop once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;

endmodule

// ===== rtl/hufd_dp.sv =====
// Datapath: item registers, node store, root node, cursor, fill count and result.
module hufd_dp import hufd_pkg::*; #(
	parameter int MAX_NODES    = DEF_MAX_NODES,
	parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  cmd_t    cmd,
	output sts_t    sts,
	output result_t result
);

	localparam int IW = $clog2(MAX_NODES);
	localparam int NW = $clog2(MAX_NODES + 1);
	localparam int LW = $clog2(MAX_CODE_LEN + 1);
	localparam int EW = 2 * IW + SYM_W;

	// Item registers
	logic              kind_q;
	logic [SYM_W-1:0]  sym_q;
	logic [CODE_W-1:0] code_q;
	logic              bit_q;
	logic [LW-1:0]     len_q;

	// Walk state
	logic [IW-1:0]     node_q;
	logic [IW-1:0]     cursor_q;
	logic [NW-1:0]     nodes_used_q;

	// Root node held in flops, the store only holds allocated nodes
	logic [IW-1:0]     root_l_q;
	logic [IW-1:0]     root_r_q;
	logic [SYM_W-1:0]  root_sym_q;
	logic              rd_root_q;

	result_t           res_q;
	result_t           out_q;

	logic              mem_wr_en;
	logic [IW-1:0]     mem_wr_addr;
	logic [EW-1:0]     mem_wr_data;
	logic [EW-1:0]     mem_rd_data;

	logic [IW-1:0]     ev_l;
	logic [IW-1:0]     ev_r;
	logic [SYM_W-1:0]  ev_sym;
	logic [31:0]       len_in;
	logic [31:0]       len_clamp;
	logic [31:0]       pos;
	logic              code_bit;
	logic              sel_bit;
	logic [IW-1:0]     link;
	logic [IW-1:0]     new_idx;
	logic              node_is_root;

	hufd_node_mem #(
		.DEPTH (MAX_NODES),
		.WIDTH (EW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (cmd.rd),
		.rd_addr (node_q),
		.rd_data (mem_rd_data)
	);

	// Clamp the code length
	assign len_in    = 32'(item.code_length);
	assign len_clamp = (len_in > 32'(MAX_CODE_LEN)) ? 32'(MAX_CODE_LEN) : len_in;

	// Select root flops or store data for the node just read
	assign ev_l   = rd_root_q ? root_l_q   : mem_rd_data[EW-1 -: IW];
	assign ev_r   = rd_root_q ? root_r_q   : mem_rd_data[SYM_W + IW - 1 -: IW];
	assign ev_sym = rd_root_q ? root_sym_q : mem_rd_data[SYM_W-1:0];

	// Pick the branch bit, code bits above the field read as zero
	assign pos      = 32'(len_q) - 32'd1;
	assign code_bit = (pos < 32'(CODE_W)) ? code_q[pos[3:0]] : 1'b0;
	assign sel_bit  = (kind_q == KIND_DECODE) ? bit_q : code_bit;
	assign link     = sel_bit ? ev_r : ev_l;
	assign new_idx  = nodes_used_q[IW-1:0];
	assign node_is_root = (node_q == '0);

	// Status to the controller
	assign sts.is_dec     = (kind_q == KIND_DECODE);
	assign sts.len_zero   = (len_q == '0);
	assign sts.link_none  = (link == '0);
	assign sts.both_none  = (ev_l == '0) && (ev_r == '0);
	assign sts.store_full = (nodes_used_q == NW'(MAX_NODES));

	// Store writes: link a new child, clear a new node, tag a node
	always_comb begin
		mem_wr_en   = cmd.wr_init || ((cmd.wr_link || cmd.wr_tag) && !node_is_root);
		mem_wr_addr = cmd.wr_init ? new_idx : node_q;
		if (cmd.wr_init) begin
			mem_wr_data = '0;
		end else if (cmd.wr_tag) begin
			mem_wr_data = {ev_l, ev_r, sym_q};
		end else if (sel_bit) begin
			mem_wr_data = {ev_l, new_idx, ev_sym};
		end else begin
			mem_wr_data = {new_idx, ev_r, ev_sym};
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			kind_q <= item.kind;
			sym_q  <= item.symbol;
			code_q <= item.code_bits;
			bit_q  <= item.bit_req;
		end
	end

	// Walk node and remaining code length
	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			node_q <= (item.kind == KIND_DECODE) ? cursor_q : '0;
			len_q  <= LW'(len_clamp);
		end else if (cmd.wr_init) begin
			node_q <= new_idx;
			len_q  <= len_q - LW'(1);
		end else if (cmd.adv_link) begin
			node_q <= link;
			if (kind_q == KIND_INSERT) begin
				len_q <= len_q - LW'(1);
			end
		end
	end

	// Remember whether the pending read targets the root
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_root_q <= node_is_root;
		end
	end

	// Root node, fill count and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_l_q     <= '0;
			root_r_q     <= '0;
			root_sym_q   <= '0;
			nodes_used_q <= NW'(1);
			cursor_q     <= '0;
		end else begin
			if (cmd.wr_link && node_is_root) begin
				if (sel_bit) begin
					root_r_q <= new_idx;
				end else begin
					root_l_q <= new_idx;
				end
			end
			if (cmd.wr_tag && node_is_root) begin
				root_sym_q <= sym_q;
			end
			if (cmd.wr_init) begin
				nodes_used_q <= nodes_used_q + NW'(1);
			end
			if (cmd.cur_zero) begin
				cursor_q <= '0;
			end else if (cmd.cur_node) begin
				cursor_q <= node_q;
			end
		end
	end

	// Build the result, then hand it to the output register
	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			case (cmd.res)
				RES_OK:      res_q <= '{symbol_valid: 1'b0, out_symbol: '0, status: ST_OK};
				RES_MISSING: res_q <= '{symbol_valid: 1'b0, out_symbol: '0, status: ST_MISSING};
				RES_FULL:    res_q <= '{symbol_valid: 1'b0, out_symbol: '0, status: ST_FULL};
				RES_SYMBOL:  res_q <= '{symbol_valid: 1'b1, out_symbol: ev_sym, status: ST_OK};
				default:     res_q <= '{symbol_valid: 1'b0, out_symbol: '0, status: ST_OK};
			endcase
		end
		if (cmd.ld_out) begin
			out_q <= res_q;
		end
	end

	assign result = out_q;

endmodule

// ===== rtl/huffman_tree_decoder.sv =====
// Bit-serial Huffman decoder top level with a bounded node store.
//
// Input channel (item_valid, item_stall, item) takes one transaction at a
// time: an insert adds a code of up to MAX_CODE_LEN bits, most significant
// first, and tags its final node with the symbol; a decode moves the cursor
// by one bit and emits the symbol when it lands on a leaf.
// Output channel (result_valid, result_stall, result) returns exactly one
// transaction per accepted item, in order.
// The node store has one registered read port, so every tree step is a
// read state followed by an evaluate state. A decode reads and evaluates
// the cursor node, then the child it moves to (only the first on a
// missing branch). An insert walks each existing node on the path, adds
// an initialize state per newly allocated node, then tags and hands off.
// The result sits in an output register; while the receiver stalls it
// holds, the next item is still accepted and worked on, and its result
// waits inside until the output register frees up.
// Reset clears the root node, the cursor and the fill count; nodes in the
// store are cleared as they are allocated, so no clearing pass is needed.
module huffman_tree_decoder import hufd_pkg::*; #(
	parameter int MAX_NODES    = DEF_MAX_NODES,
	parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	cmd_t cmd;
	sts_t sts;

	hufd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_kind    (item.kind),
		.result_stall (result_stall),
		.sts          (sts),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.cmd          (cmd)
	);

	hufd_dp #(
		.MAX_NODES    (MAX_NODES),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

	// Never allocate a node once the store is full
	a_no_alloc_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_init |-> !sts.store_full)
		else $error("node allocated with a full store");

	// Only insert transactions write the tree
	a_write_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_link || cmd.wr_init || cmd.wr_tag) |-> !sts.is_dec)
		else $error("tree written during a decode");

	// An accepted transaction keeps the block busy the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("second transaction accepted back to back");

	// A link write to the tree is always followed by initializing the new node
	a_link_then_init: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_link |=> cmd.wr_init)
		else $error("child linked without node initialization");

endmodule
